// ----- rtl/ordered_id_list_defines.svh -----
// ----------------------------------------------------------------------------
// ordered_id_list_defines.svh
// Assertion macros shared by the ordered identifier list RTL. They expect
// clk_i and rst_ni to be visible at the point of use.
// ----------------------------------------------------------------------------
`ifndef ORDERED_ID_LIST_DEFINES_SVH
`define ORDERED_ID_LIST_DEFINES_SVH

// Property must hold at every clock edge outside reset.
`define OIL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define OIL_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ----- rtl/oil_pkg.sv -----
// ----------------------------------------------------------------------------
// oil_pkg
// Shared constants for the ordered identifier list: field widths, default
// depth, operation and status codes.
// ----------------------------------------------------------------------------
package oil_pkg;

  // Field widths
  localparam int unsigned IdW    = 16;
  localparam int unsigned FuncW  = 2;
  localparam int unsigned PosW   = 5;
  localparam int unsigned StatW  = 2;
  localparam int unsigned CntOutW = 5;

  // Default list depth
  localparam int unsigned DefDepth = 16;

  // Operation codes
  typedef enum logic [FuncW-1:0] {
    FuncAppend = 2'd0,
    FuncRemove = 2'd1,
    FuncRead   = 2'd2,
    FuncClear  = 2'd3
  } func_e;

  // Result status codes
  typedef enum logic [StatW-1:0] {
    StatOk      = 2'd0,
    StatFull    = 2'd1,
    StatMissing = 2'd2,
    StatHead    = 2'd3
  } status_e;

endpackage

// ----- rtl/ordered_id_list.sv -----
// ----------------------------------------------------------------------------
// ordered_id_list
// Ordered list of up to DEPTH 16-bit identifiers held in one RAM, with
// append, remove-by-identifier, read-at-position and clear requests.
// ----------------------------------------------------------------------------
// One request is worked on at a time and each gives exactly one result.
// Append and clear finish in the accept cycle; read issues one RAM read and
// finishes once the data is back. Remove walks the list through the RAM's single
// read port, one entry per cycle, then shifts the tail down one entry per
// cycle; on an empty list it reports not-found in the accept cycle. The count
// is a register, so no clearing pass is needed after reset. A finished result
// sits in the output register; a next request is accepted while it waits, and
// its own result is held back until the output register is free.
`include "ordered_id_list_defines.svh"

module ordered_id_list
  import oil_pkg::*;
#(
  parameter int unsigned DEPTH = DefDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // request channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [FuncW-1:0]   func_i,
  input  logic [IdW-1:0]     ship_id_i,
  input  logic [PosW-1:0]    position_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [StatW-1:0]   status_o,
  output logic [IdW-1:0]     id_out_o,
  output logic [CntOutW-1:0] count_out_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned PW = (CW > PosW) ? CW : PosW;

  // FSM codes
  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StRdWait = 3'd1;
  localparam logic [2:0] StSearch = 3'd2;
  localparam logic [2:0] StShift  = 3'd3;
  localparam logic [2:0] StPost   = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [CW-1:0]      count_q, count_d;
  logic [AW-1:0]      idx_q, idx_d;
  logic [IdW-1:0]     key_q, key_d;
  logic               out_valid_q, out_valid_d;
  logic               out_load;
  logic [StatW-1:0]   out_status_q, out_status_d;
  logic [IdW-1:0]     out_id_q, out_id_d;
  logic [CntOutW-1:0] out_count_q, out_count_d;
  logic [StatW-1:0]   res_status_q;
  logic [IdW-1:0]     res_id_q;
  logic               res_load;

  // RAM port signals
  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [IdW-1:0]     ram_wdata, ram_rdata;

  // Finish strobe for the request in work
  logic               fin;
  logic [StatW-1:0]   fin_status;
  logic [IdW-1:0]     fin_id;

  logic               in_acc, slot_free, at_last;
  logic [PW-1:0]      rd_pos;

  assign in_stall_o = (state_q != StIdle);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign slot_free  = !out_valid_q || !out_stall_i;
  assign at_last    = (CW'(idx_q) == (count_q - CW'(1)));
  assign rd_pos     = (PW'(position_i) < PW'(count_q)) ? PW'(position_i) : PW'(count_q);

  oil_ram #(
    .Width (IdW),
    .Depth (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Request sequencing: search, shift and RAM access
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    idx_d      = idx_q;
    key_d      = key_q;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = '0;
    ram_re     = 1'b0;
    ram_raddr  = '0;
    fin        = 1'b0;
    fin_status = StatOk;
    fin_id     = '0;

    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          key_d = ship_id_i;
          unique case (func_e'(func_i))
            FuncAppend: begin
              fin = 1'b1;
              if (count_q >= CW'(DEPTH)) begin
                fin_status = StatFull;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = AW'(count_q);
                ram_wdata = ship_id_i;
                count_d   = count_q + CW'(1);
              end
            end
            FuncRemove: begin
              if (count_q == '0) begin
                fin        = 1'b1;
                fin_status = StatMissing;
              end else begin
                ram_re  = 1'b1;
                idx_d   = '0;
                state_d = StSearch;
              end
            end
            FuncRead: begin
              if (position_i == '0 || count_q == '0) begin
                fin        = 1'b1;
                fin_status = StatHead;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = AW'(rd_pos - PW'(1));
                state_d   = StRdWait;
              end
            end
            FuncClear: begin
              fin     = 1'b1;
              count_d = '0;
            end
            default: ;
          endcase
        end
      end
      StRdWait: begin
        fin    = 1'b1;
        fin_id = ram_rdata;
      end
      StSearch: begin
        // entry idx_q is on the read data now
        if (at_last) begin
          fin = 1'b1;
          if (ram_rdata == key_q) begin
            fin_id  = key_q;
            count_d = count_q - CW'(1);
          end else begin
            fin_status = StatMissing;
          end
        end else begin
          ram_re    = 1'b1;
          ram_raddr = idx_q + AW'(1);
          idx_d     = idx_q + AW'(1);
          if (ram_rdata == key_q) begin
            state_d = StShift;
          end
        end
      end
      StShift: begin
        // move entry idx_q down one place
        ram_we    = 1'b1;
        ram_waddr = idx_q - AW'(1);
        ram_wdata = ram_rdata;
        if (at_last) begin
          fin     = 1'b1;
          fin_id  = key_q;
          count_d = count_q - CW'(1);
        end else begin
          ram_re    = 1'b1;
          ram_raddr = idx_q + AW'(1);
          idx_d     = idx_q + AW'(1);
        end
      end
      StPost: begin
        if (slot_free) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    if (fin) begin
      state_d = slot_free ? StIdle : StPost;
    end
  end

  // Output register loading
  always_comb begin
    out_valid_d  = out_valid_q && out_stall_i;
    out_load     = 1'b0;
    res_load     = 1'b0;
    out_status_d = fin_status;
    out_id_d     = fin_id;
    out_count_d  = CntOutW'(count_d);
    if (fin) begin
      if (slot_free) begin
        out_load    = 1'b1;
        out_valid_d = 1'b1;
      end else begin
        res_load = 1'b1;
      end
    end else if (state_q == StPost && slot_free) begin
      out_load     = 1'b1;
      out_valid_d  = 1'b1;
      out_status_d = res_status_q;
      out_id_d     = res_id_q;
      out_count_d  = CntOutW'(count_q);
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    key_q <= key_d;
    if (res_load) begin
      res_status_q <= fin_status;
      res_id_q     <= fin_id;
    end
    if (out_load) begin
      out_status_q <= out_status_d;
      out_id_q     <= out_id_d;
      out_count_q  <= out_count_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign id_out_o    = out_id_q;
  assign count_out_o = out_count_q;

  // Checks
  `OIL_ASSERT(a_count_range, count_q <= CW'(DEPTH), "entry count above depth")
  `OIL_ASSERT_NEVER(a_ram_same_addr, ram_we && ram_re && (ram_waddr == ram_raddr), "RAM read and write hit the same entry")
  `OIL_ASSERT(a_post_holds, (state_q == StPost) |-> out_valid_q, "pending result without a busy output register")
  `OIL_ASSERT(a_shift_idx, (state_q == StShift) |-> ((CW'(idx_q) < count_q) && (idx_q != '0)), "shift index out of range")
  `OIL_ASSERT(a_append_count, (in_acc && func_i == FuncAppend && count_q < CW'(DEPTH)) |=> (count_q == $past(count_q) + CW'(1)), "append did not grow the list")

endmodule

// ----- rtl/oil_ram.sv -----
// ----------------------------------------------------------------------------
// oil_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data. No reset on the array.
// ----------------------------------------------------------------------------
module oil_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench for ordered_id_list
// Drives append, remove, read and clear requests into the ordered identifier
// list and predicts every result with a queue-based copy of the list. Results
// are compared field by field in order. Both channels idle and stall at
// random, with one long result hold-off and one source pause that lets the
// list drain. A watchdog ends the run if traffic stops.
// ----------------------------------------------------------------------------
module testbench;
  import oil_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH        = DefDepth;
  localparam int unsigned DRAIN_CYCLES = 4 * DEPTH;
  localparam int unsigned IDLE_LIMIT   = 2000;

  typedef struct packed {
    status_e             status;
    logic [IdW-1:0]      id;
    logic [CntOutW-1:0]  count;
  } list_result_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [FuncW-1:0]   func_i;
  logic [IdW-1:0]     ship_id_i;
  logic [PosW-1:0]    position_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [StatW-1:0]   status_o;
  logic [IdW-1:0]     id_out_o;
  logic [CntOutW-1:0] count_out_o;

  // predictor state and the results it has worked out, oldest first
  logic [IdW-1:0] id_list[$];
  list_result_t   predicted_results[$];

  int unsigned error_count   = 0;
  int unsigned send_gap_max  = 10;
  int unsigned recv_gap_max  = 10;
  int unsigned sink_hold_req = 0;
  int unsigned idle_cycles   = 0;

  ordered_id_list #(
    .DEPTH (DEPTH)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .ship_id_i   (ship_id_i),
    .position_i  (position_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .id_out_o    (id_out_o),
    .count_out_o (count_out_o)
  );

  // 12 ns clock
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Apply one request to the list copy and return the result it gives
  function automatic list_result_t list_predict(func_e f, logic [IdW-1:0] id,
                                                logic [PosW-1:0] pos);
    list_result_t r;
    int hit;
    int unsigned p;
    r.status = StatOk;
    r.id     = '0;
    hit      = -1;
    case (f)
      FuncAppend: begin
        if (id_list.size() >= DEPTH) r.status = StatFull;
        else id_list.push_back(id);
      end
      FuncRemove: begin
        // first match only; later duplicates stay
        foreach (id_list[i]) if (hit < 0 && id_list[i] == id) hit = i;
        if (hit < 0) begin
          r.status = StatMissing;
        end else begin
          r.id = id_list[hit];
          id_list.delete(hit);
        end
      end
      FuncRead: begin
        if (pos == 0 || id_list.size() == 0) begin
          r.status = StatHead;
        end else begin
          // past the end reads the tail entry
          p    = (pos < id_list.size()) ? pos : id_list.size();
          r.id = id_list[p-1];
        end
      end
      default: id_list.delete();
    endcase
    r.count = CntOutW'(id_list.size());
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned want, int unsigned got);
    $display("%0t ns: %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
    error_count++;
  endtask

  // Predict on every accepted request, check every accepted result
  always @(posedge clk_i) begin : result_check
    list_result_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        predicted_results.push_back(list_predict(func_e'(func_i), ship_id_i, position_i));
      if (out_valid_o && !out_stall_i) begin
        if (predicted_results.size() == 0) begin
          report_mismatch("result with no request pending", 0, status_o);
        end else begin
          want = predicted_results.pop_front();
          if (status_o !== want.status) report_mismatch("status", want.status, status_o);
          if (id_out_o !== want.id) report_mismatch("id_out", want.id, id_out_o);
          if (count_out_o !== want.count) report_mismatch("count_out", want.count, count_out_o);
        end
      end
    end
  end

  // Watchdog: cycles with no transfer on either channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t ns: no traffic for %0d cycles", $time, IDLE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Result sink: random hold-off per result, or a long one when asked
  initial begin : result_sink
    int unsigned hold;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (sink_hold_req > 0) begin
        hold          = sink_hold_req;
        sink_hold_req = 0;
      end else begin
        hold = $urandom_range(recv_gap_max, 0);
      end
      if (hold > 0) begin
        @(negedge clk_i);
        out_stall_i = 1'b1;
        repeat (hold) @(negedge clk_i);
        out_stall_i = 1'b0;
      end
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  // Offer one request after a random gap and hold it until taken
  task automatic send_request(func_e f, logic [IdW-1:0] id, logic [PosW-1:0] pos);
    int unsigned gap;
    gap = $urandom_range(send_gap_max, 0);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    func_i     = f;
    ship_id_i  = id;
    position_i = pos;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Stop offering, then wait for every outstanding result
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (predicted_results.size() != 0) @(posedge clk_i);
  endtask

  // Empty-list cases, field extremes, duplicates, head and past-end reads
  task automatic test_directed_ops();
    send_request(FuncRead,   16'h0000, 5'd0);
    send_request(FuncRead,   16'h0000, 5'd5);
    send_request(FuncRemove, 16'h0000, 5'd0);
    send_request(FuncAppend, 16'h0000, 5'd0);
    send_request(FuncAppend, 16'hFFFF, 5'd31);
    send_request(FuncAppend, 16'h1234, 5'd0);
    send_request(FuncAppend, 16'h1234, 5'd0);
    send_request(FuncRead,   16'hFFFF, 5'd0);
    send_request(FuncRead,   16'h0000, 5'd1);
    send_request(FuncRead,   16'h0000, 5'd16);
    send_request(FuncRead,   16'h0000, 5'd3);
    send_request(FuncRemove, 16'hAAAA, 5'd0);
    send_request(FuncRemove, 16'h1234, 5'd0);
    send_request(FuncRemove, 16'h0000, 5'd0);
    send_request(FuncRead,   16'h0000, 5'd2);
    send_request(FuncClear,  16'hFFFF, 5'd16);
    send_request(FuncRead,   16'h0000, 5'd1);
  endtask

  // Fill to DEPTH, overflow, remove the tail, refill, read the last entry
  task automatic test_full_list();
    logic [IdW-1:0] tail_id;
    repeat (DEPTH) send_request(FuncAppend, 16'($urandom_range(16'hFFFF, 0)), 5'd0);
    send_request(FuncAppend, 16'hBEEF, 5'd0);
    send_request(FuncRead, 16'h0000, 5'd16);
    tail_id = id_list[$];
    send_request(FuncRemove, tail_id, 5'd0);
    send_request(FuncAppend, 16'h5A5A, 5'd0);
    send_request(FuncRead, 16'h0000, 5'd16);
    send_request(FuncClear, 16'h0000, 5'd0);
  endtask

  // Random traffic in phases that grow, shrink or hold the list size
  task automatic test_random_traffic(int unsigned n_items);
    int unsigned k, roll, mode, app_t, rem_t;
    func_e f;
    logic [IdW-1:0] id;
    logic [PosW-1:0] pos;
    mode = 0;
    for (k = 0; k < n_items; k++) begin
      if (k % 48 == 0) mode = $urandom_range(2, 0);
      case (mode)
        0:       begin app_t = 60; rem_t = 75; end
        1:       begin app_t = 15; rem_t = 75; end
        default: begin app_t = 38; rem_t = 76; end
      endcase
      roll = $urandom_range(99, 0);
      if (roll < app_t)      f = FuncAppend;
      else if (roll < rem_t) f = FuncRemove;
      else if (roll < 98)    f = FuncRead;
      else                   f = FuncClear;
      // mostly remove entries that are present; sometimes reuse ids
      if (f == FuncRemove && id_list.size() != 0 && $urandom_range(4, 0) != 0)
        id = id_list[$urandom_range(id_list.size() - 1, 0)];
      else if (f == FuncAppend && id_list.size() != 0 && $urandom_range(3, 0) == 0)
        id = id_list[$urandom_range(id_list.size() - 1, 0)];
      else if ($urandom_range(3, 0) == 0)
        id = $urandom_range(1, 0) ? 16'hFFFF - 16'($urandom_range(3, 0))
                                  : 16'($urandom_range(3, 0));
      else
        id = 16'($urandom_range(16'hFFFF, 0));
      if (id_list.size() != 0 && $urandom_range(1, 0) != 0)
        pos = 5'($urandom_range(id_list.size(), 1));
      else
        pos = 5'($urandom_range(DEPTH, 0));
      send_request(f, id, pos);
    end
  endtask

  // Long result hold-off while requests keep coming back to back
  task automatic test_result_backpressure();
    wait_drained();
    sink_hold_req = 150;
    send_gap_max  = 0;
    test_random_traffic(40);
    send_gap_max  = 10;
  endtask

  // Source stops until every result is back, then resumes
  task automatic test_paused_source();
    test_random_traffic(20);
    wait_drained();
    test_random_traffic(20);
  endtask

  // No idling on either side
  task automatic test_no_idle();
    send_gap_max = 0;
    recv_gap_max = 0;
    test_random_traffic(100);
    send_gap_max = 10;
    recv_gap_max = 10;
  endtask

  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    func_i     = FuncAppend;
    ship_id_i  = '0;
    position_i = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_ops();
    test_full_list();
    test_random_traffic(600);
    test_result_backpressure();
    test_paused_source();
    test_no_idle();
    test_random_traffic(60);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (predicted_results.size() != 0)
      report_mismatch("results never delivered", 0, predicted_results.size());

    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- ordered_id_list.f -----
+incdir+rtl
rtl/oil_pkg.sv
rtl/oil_ram.sv
rtl/ordered_id_list.sv
test/testbench.sv
